// ===== src/i2cwb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cwb_pkg
// Types and constants shared by the I2C register-write phase sequencer.
// ----------------------------------------------------------------------------
package i2cwb_pkg;

  localparam int unsigned ByteW = 8;

  // Reset value of the device address byte (write bit included)
  localparam logic [ByteW-1:0] DEV_ADDR_RESET = 8'hC0;

  // Request op codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Step counters: bit index 0..7 are data bits, 8 is the ack clock
  localparam logic [3:0] ACK_BIT       = 4'd8;
  localparam logic [1:0] START_LAST_SUB = 2'd3;
  localparam logic [1:0] BYTE_LAST_SUB  = 2'd2;
  localparam logic [1:0] STOP_LAST_SUB  = 2'd2;

  localparam logic [1:0] SUB_SET_DATA = 2'd0;
  localparam logic [1:0] SUB_CLK_HIGH = 2'd1;
  localparam logic [1:0] SUB_CLK_LOW  = 2'd2;

  // Bus segment being sent
  typedef enum logic [1:0] {
    SEG_START,
    SEG_ADDR,
    SEG_DATA,
    SEG_STOP
  } seg_e;

endpackage

// ===== src/i2c_register_write_bitbang.sv =====
// ----------------------------------------------------------------------------
// i2c_register_write_bitbang
// Write-only I2C master that turns register-write requests into pin phases.
// ----------------------------------------------------------------------------
// Each accepted request becomes a run of SDA/SCL pin phases, one phase per
// output transfer. A header request (op = 0) gives start, the device address
// byte and the register address byte: 58 phases, 61 with stop. A data request
// (op = 1) gives one byte plus ack clock: 27 phases, 30 with stop. Bytes go out
// MSB first; the ack clock drives SDA low. With out_ready_i held high one phase
// is delivered per cycle, paced by the single phase sequencer; the first phase
// of the next request follows the last phase of the previous one in the very
// next cycle, since a one-entry request buffer is filled while the current
// run is still going. end_of_run_o flags the final phase of each run. The user
// must write the device address register through the cfg port only while the
// block is idle, which is not enforced; it is sampled as a header run starts.
// ----------------------------------------------------------------------------
module i2c_register_write_bitbang
  import i2cwb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ByteW-1:0] cfg_wdata_i,
  // request channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [ByteW-1:0] value_i,
  input  logic             last_i,
  // phase channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             sda_o,
  output logic             scl_o,
  output logic             long_hold_o,
  output logic             end_of_run_o
);

  // Device address register
  logic [ByteW-1:0] dev_addr_q;

  // One-entry request buffer
  logic             pend_valid_q, pend_valid_d;
  logic             pend_op_q;
  logic [ByteW-1:0] pend_value_q;
  logic             pend_last_q;

  // Sequencer state
  logic             busy_q, busy_d;
  seg_e             seg_q, seg_d;
  logic [3:0]       bit_q, bit_d;
  logic [1:0]       sub_q, sub_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [ByteW-1:0] reg_q, reg_d;
  logic             last_q, last_d;

  // Pin levels as last written
  logic sda_q, scl_q;

  // Phase output register
  logic out_valid_q, out_valid_d;
  logic out_sda_q, out_scl_q, out_long_q, out_end_q;

  // Working view: running request, or the buffered one when idle
  logic             cur_valid;
  seg_e             cur_seg;
  logic [3:0]       cur_bit;
  logic [1:0]       cur_sub;
  logic [ByteW-1:0] cur_byte;
  logic [ByteW-1:0] cur_reg;
  logic             cur_last;
  logic             advance;
  logic             in_accept;

  // Phase being produced this cycle
  logic ph_sda, ph_scl, ph_long, ph_final;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !pend_valid_q;
  assign in_accept   = in_valid_i && in_ready_o;

  assign cur_valid = busy_q || pend_valid_q;
  assign cur_seg   = busy_q ? seg_q : ((pend_op_q == OP_HEADER) ? SEG_START : SEG_DATA);
  assign cur_bit   = busy_q ? bit_q : '0;
  assign cur_sub   = busy_q ? sub_q : '0;
  assign cur_byte  = busy_q ? byte_q
                            : ((pend_op_q == OP_HEADER) ? dev_addr_q : pend_value_q);
  assign cur_reg   = busy_q ? reg_q  : pend_value_q;
  assign cur_last  = busy_q ? last_q : pend_last_q;

  // A phase moves into the output register when that slot is free
  assign advance = cur_valid && (!out_valid_q || out_ready_i);

  // Phase outputs: one pin write per phase, the other pin keeps its level
  always_comb begin
    ph_sda   = sda_q;
    ph_scl   = scl_q;
    ph_long  = 1'b0;
    ph_final = 1'b0;
    unique case (cur_seg)
      SEG_START: begin
        unique case (cur_sub)
          2'd0: ph_sda = 1'b1;
          2'd1: begin
            ph_scl  = 1'b1;
            ph_long = 1'b1;
          end
          2'd2: ph_sda = 1'b0;
          default: ph_scl = 1'b0;
        endcase
      end
      SEG_ADDR, SEG_DATA: begin
        unique case (cur_sub)
          SUB_SET_DATA: ph_sda = (cur_bit == ACK_BIT) ? 1'b0 : cur_byte[ByteW-1];
          SUB_CLK_HIGH: begin
            ph_scl  = 1'b1;
            ph_long = 1'b1;
          end
          default: begin
            ph_scl = 1'b0;
            // run ends after the ack of the final byte when no stop follows
            ph_final = (cur_seg == SEG_DATA) && (cur_bit == ACK_BIT) && !cur_last;
          end
        endcase
      end
      default: begin
        unique case (cur_sub)
          SUB_SET_DATA: ph_sda = 1'b0;
          SUB_CLK_HIGH: begin
            ph_scl  = 1'b1;
            ph_long = 1'b1;
          end
          default: begin
            ph_sda   = 1'b1;
            ph_final = 1'b1;
          end
        endcase
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    seg_d  = cur_seg;
    bit_d  = cur_bit;
    sub_d  = cur_sub + 2'd1;
    byte_d = cur_byte;
    reg_d  = cur_reg;
    last_d = cur_last;
    busy_d = busy_q;
    if (advance) begin
      busy_d = !ph_final;
      unique case (cur_seg)
        SEG_START: begin
          if (cur_sub == START_LAST_SUB) begin
            seg_d = SEG_ADDR;
            bit_d = '0;
            sub_d = '0;
          end
        end
        SEG_ADDR, SEG_DATA: begin
          if (cur_sub == BYTE_LAST_SUB) begin
            sub_d = '0;
            if (cur_bit == ACK_BIT) begin
              bit_d = '0;
              if (cur_seg == SEG_ADDR) begin
                seg_d  = SEG_DATA;
                byte_d = cur_reg;
              end else begin
                seg_d = SEG_STOP;
              end
            end else begin
              bit_d  = cur_bit + 4'd1;
              byte_d = {cur_byte[ByteW-2:0], 1'b0};
            end
          end
        end
        default: begin
          if (cur_sub == STOP_LAST_SUB) begin
            sub_d = '0;
          end
        end
      endcase
    end
  end

  // Buffer fills on accept, empties when an idle sequencer takes it up
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (in_accept) begin
      pend_valid_d = 1'b1;
    end else if (advance && !busy_q) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= DEV_ADDR_RESET;
      pend_valid_q <= 1'b0;
      busy_q       <= 1'b0;
      seg_q        <= SEG_START;
      bit_q        <= '0;
      sub_q        <= '0;
      sda_q        <= 1'b1;
      scl_q        <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      pend_valid_q <= pend_valid_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      if (advance) begin
        seg_q <= seg_d;
        bit_q <= bit_d;
        sub_q <= sub_d;
        sda_q <= ph_sda;
        scl_q <= ph_scl;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_op_q    <= op_i;
      pend_value_q <= value_i;
      pend_last_q  <= last_i;
    end
    if (advance) begin
      byte_q     <= byte_d;
      reg_q      <= reg_d;
      last_q     <= last_d;
      out_sda_q  <= ph_sda;
      out_scl_q  <= ph_scl;
      out_long_q <= ph_long;
      out_end_q  <= ph_final;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sda_o        = out_sda_q;
  assign scl_o        = out_scl_q;
  assign long_hold_o  = out_long_q;
  assign end_of_run_o = out_end_q;

endmodule

// ===== src/i2cwb_checker.sv =====
// ----------------------------------------------------------------------------
// i2cwb_checker
// Port-level checks for the I2C register-write phase sequencer.
// ----------------------------------------------------------------------------
module i2cwb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic sda_o,
  input logic scl_o,
  input logic long_hold_o,
  input logic end_of_run_o
);

  // Stalled phase holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sda_o) && $stable(scl_o)
      && $stable(long_hold_o) && $stable(end_of_run_o))
    else $error("phase changed while stalled");

  // Long hold only follows raising SCL
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && long_hold_o |-> scl_o && !end_of_run_o)
    else $error("long hold without SCL high");

  // One-entry buffer is full after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request buffer not full after accept");

  // A run ends with SCL low (no stop) or both pins released (stop)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_run_o |-> (!scl_o && !sda_o) || (scl_o && sda_o))
    else $error("bad final pin state");

endmodule

bind i2c_register_write_bitbang i2cwb_checker u_i2cwb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sda_o        (sda_o),
  .scl_o        (scl_o),
  .long_hold_o  (long_hold_o),
  .end_of_run_o (end_of_run_o)
);
